// ===== rtl/dspd_pkg.sv =====
// ----------------------------------------------------------------------------
// dspd_pkg
// Shared types and constants of the two-sided proportional drive controller.
// ----------------------------------------------------------------------------
package dspd_pkg;

   // Field widths
   localparam int POS_W    = 21;            // encoder position and distance
   localparam int TGT_W    = POS_W + 1;     // latched target
   localparam int ERR_W    = TGT_W + 1;     // target minus position
   localparam int GAIN_W   = 12;            // unsigned Q4.8 gain
   localparam int GAIN_FRAC = 8;
   localparam int PROD_W   = ERR_W + GAIN_W;
   localparam int SCALED_W = PROD_W - GAIN_FRAC;   // product without its fraction
   localparam int DRV_W    = 8;             // signed drive value
   localparam int CAP_W    = 7;             // slew cap, ramp and limit
   localparam int CNT_W    = 5;             // unchanged-error tick count
   localparam int PREV_W   = 22;            // stored mean error

   // Settling rules
   localparam int SETTLE_TICKS = 20;
   localparam int CLOSE_ERROR  = 5;

   // Configuration port
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;
   localparam int CSR_IW = 3;               // register index bits of paddr

   localparam logic [CSR_IW-1:0] REG_GAIN_STRAIGHT = 3'd0;
   localparam logic [CSR_IW-1:0] REG_GAIN_TURN     = 3'd1;
   localparam logic [CSR_IW-1:0] REG_RAMP_STRAIGHT = 3'd2;
   localparam logic [CSR_IW-1:0] REG_RAMP_TURN     = 3'd3;
   localparam logic [CSR_IW-1:0] REG_DRIVE_LIMIT   = 3'd4;

   localparam logic [GAIN_W-1:0] GAIN_STRAIGHT_RST = 12'd38;
   localparam logic [GAIN_W-1:0] GAIN_TURN_RST     = 12'd179;
   localparam logic [CAP_W-1:0]  RAMP_STRAIGHT_RST = 7'd5;
   localparam logic [CAP_W-1:0]  RAMP_TURN_RST     = 7'd4;
   localparam logic [CAP_W-1:0]  DRIVE_LIMIT_RST   = 7'd115;

   // Command codes
   localparam logic CMD_START  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   typedef struct packed {
      logic [GAIN_W-1:0] gain_straight;
      logic [GAIN_W-1:0] gain_turn;
      logic [CAP_W-1:0]  ramp_straight;
      logic [CAP_W-1:0]  ramp_turn;
      logic [CAP_W-1:0]  drive_limit;
   } cfg_type;

   typedef struct packed {
      logic                    command;
      logic signed [POS_W-1:0] left_position;
      logic signed [POS_W-1:0] right_position;
      logic signed [POS_W-1:0] left_distance;
      logic signed [POS_W-1:0] right_distance;
   } item_type;

   typedef struct packed {
      logic signed [DRV_W-1:0] left_drive;
      logic signed [DRV_W-1:0] right_drive;
      logic                    finished;
      logic                    running;
   } result_type;

   // Per-side error summary and clamped drive
   typedef struct packed {
      logic              negative;
      logic              zero;
      logic [ERR_W-1:0]  magnitude;
      logic [DRV_W-1:0]  drive;
   } side_type;

endpackage

// ===== rtl/dspd_csr.sv =====
// ----------------------------------------------------------------------------
// dspd_csr
// Configuration registers behind the APB-style port, with read-back.
// ----------------------------------------------------------------------------
module dspd_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [dspd_pkg::CSR_AW-1:0]   paddr,
   input  logic [dspd_pkg::CSR_DW-1:0]   pwdata,
   output logic [dspd_pkg::CSR_DW-1:0]   prdata,
   output logic                          pready,
   output dspd_pkg::cfg_type             cfg
);

   dspd_pkg::cfg_type           cfg_ff;
   dspd_pkg::cfg_type           cfg_in;
   logic [dspd_pkg::CSR_IW-1:0] index;
   logic                        wr_en;

   assign pready = 1'b1;
   assign index  = paddr[dspd_pkg::CSR_AW-1:2];
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            dspd_pkg::REG_GAIN_STRAIGHT:
               cfg_in.gain_straight = pwdata[dspd_pkg::GAIN_W-1:0];
            dspd_pkg::REG_GAIN_TURN:
               cfg_in.gain_turn = pwdata[dspd_pkg::GAIN_W-1:0];
            dspd_pkg::REG_RAMP_STRAIGHT:
               cfg_in.ramp_straight = pwdata[dspd_pkg::CAP_W-1:0];
            dspd_pkg::REG_RAMP_TURN:
               cfg_in.ramp_turn = pwdata[dspd_pkg::CAP_W-1:0];
            dspd_pkg::REG_DRIVE_LIMIT:
               cfg_in.drive_limit = pwdata[dspd_pkg::CAP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_straight <= dspd_pkg::GAIN_STRAIGHT_RST;
         cfg_ff.gain_turn     <= dspd_pkg::GAIN_TURN_RST;
         cfg_ff.ramp_straight <= dspd_pkg::RAMP_STRAIGHT_RST;
         cfg_ff.ramp_turn     <= dspd_pkg::RAMP_TURN_RST;
         cfg_ff.drive_limit   <= dspd_pkg::DRIVE_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (index)
         dspd_pkg::REG_GAIN_STRAIGHT:
            prdata = dspd_pkg::CSR_DW'(cfg_ff.gain_straight);
         dspd_pkg::REG_GAIN_TURN:
            prdata = dspd_pkg::CSR_DW'(cfg_ff.gain_turn);
         dspd_pkg::REG_RAMP_STRAIGHT:
            prdata = dspd_pkg::CSR_DW'(cfg_ff.ramp_straight);
         dspd_pkg::REG_RAMP_TURN:
            prdata = dspd_pkg::CSR_DW'(cfg_ff.ramp_turn);
         dspd_pkg::REG_DRIVE_LIMIT:
            prdata = dspd_pkg::CSR_DW'(cfg_ff.drive_limit);
         default:
            prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/dspd_side.sv =====
// ----------------------------------------------------------------------------
// dspd_side
// One side of the drive: position error, its magnitude and the scaled,
// cap-limited drive value.
// ----------------------------------------------------------------------------
module dspd_side (
   input  logic signed [dspd_pkg::TGT_W-1:0]  target,
   input  logic signed [dspd_pkg::POS_W-1:0]  position,
   input  logic [dspd_pkg::GAIN_W-1:0]        gain,
   input  logic [dspd_pkg::CAP_W-1:0]         cap,
   output dspd_pkg::side_type                 side
);

   logic signed [dspd_pkg::ERR_W-1:0] err;
   logic [dspd_pkg::ERR_W-1:0]        err_mag;
   logic [dspd_pkg::PROD_W-1:0]       product;
   logic [dspd_pkg::SCALED_W-1:0]     scaled;
   logic [dspd_pkg::CAP_W-1:0]        limited;
   logic [dspd_pkg::DRV_W-1:0]        limited_ext;

   assign err     = dspd_pkg::ERR_W'(target) - dspd_pkg::ERR_W'(position);
   assign err_mag = err[dspd_pkg::ERR_W-1] ? dspd_pkg::ERR_W'(-err)
                                           : dspd_pkg::ERR_W'(err);
   assign product = dspd_pkg::PROD_W'(err_mag) * dspd_pkg::PROD_W'(gain);
   assign scaled  = product[dspd_pkg::PROD_W-1:dspd_pkg::GAIN_FRAC];

   // Drive magnitude truncates toward zero, then is held to the slew cap.
   assign limited = (scaled > dspd_pkg::SCALED_W'(cap)) ? cap : scaled[dspd_pkg::CAP_W-1:0];
   assign limited_ext = dspd_pkg::DRV_W'(limited);

   assign side.negative  = err[dspd_pkg::ERR_W-1];
   assign side.zero      = (err == '0);
   assign side.magnitude = err_mag;
   assign side.drive     = err[dspd_pkg::ERR_W-1] ? (~limited_ext + 1'b1) : limited_ext;

endmodule

// ===== rtl/dspd_ctrl.sv =====
// ----------------------------------------------------------------------------
// dspd_ctrl
// Move state and per-item control: start latching, gain and ramp choice,
// slew cap, settle detection and the result of each item.
// ----------------------------------------------------------------------------
module dspd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  dspd_pkg::item_type   item,
   input  dspd_pkg::cfg_type    cfg,
   output dspd_pkg::result_type result
);

   logic signed [dspd_pkg::TGT_W-1:0] target_left_ff,  target_left_in;
   logic signed [dspd_pkg::TGT_W-1:0] target_right_ff, target_right_in;
   logic [dspd_pkg::CAP_W-1:0]        ramp_cap_ff,     ramp_cap_in;
   logic [dspd_pkg::PREV_W-1:0]       prev_error_ff,   prev_error_in;
   logic [dspd_pkg::CNT_W-1:0]        unchanged_ff,    unchanged_in;
   logic                              active_ff,       active_in;

   dspd_pkg::side_type                left_side, right_side;
   logic                              same_sign;
   logic [dspd_pkg::GAIN_W-1:0]       gain;
   logic [dspd_pkg::CAP_W-1:0]        ramp;
   logic [dspd_pkg::CAP_W:0]          cap_sum;
   logic [dspd_pkg::CAP_W-1:0]        cap;
   logic [dspd_pkg::ERR_W:0]          mag_sum;
   logic [dspd_pkg::ERR_W-1:0]        mean_err;
   logic [dspd_pkg::CNT_W-1:0]        count_next;
   logic                              settle;

   dspd_side u_left (
      .target   (target_left_ff),
      .position (item.left_position),
      .gain     (gain),
      .cap      (cap),
      .side     (left_side)
   );

   dspd_side u_right (
      .target   (target_right_ff),
      .position (item.right_position),
      .gain     (gain),
      .cap      (cap),
      .side     (right_side)
   );

   // Two zero errors count as the same sign.
   assign same_sign = (left_side.negative == right_side.negative) &&
                      (left_side.zero == right_side.zero);
   assign gain      = same_sign ? cfg.gain_straight : cfg.gain_turn;
   assign ramp      = same_sign ? cfg.ramp_straight : cfg.ramp_turn;
   assign cap_sum   = {1'b0, ramp_cap_ff} + {1'b0, ramp};
   assign cap       = (cap_sum > {1'b0, cfg.drive_limit}) ? cfg.drive_limit
                                                          : cap_sum[dspd_pkg::CAP_W-1:0];

   assign mag_sum  = {1'b0, left_side.magnitude} + {1'b0, right_side.magnitude};
   assign mean_err = mag_sum[dspd_pkg::ERR_W:1];

   always_comb begin
      if (dspd_pkg::ERR_W'(prev_error_ff) == mean_err) begin
         count_next = (unchanged_ff == '1) ? unchanged_ff : unchanged_ff + 1'b1;
      end else begin
         count_next = '0;
      end
   end

   assign settle = ((prev_error_ff < dspd_pkg::PREV_W'(dspd_pkg::CLOSE_ERROR)) &&
                    (mean_err < dspd_pkg::ERR_W'(dspd_pkg::CLOSE_ERROR))) ||
                   (count_next >= dspd_pkg::CNT_W'(dspd_pkg::SETTLE_TICKS));

   always_comb begin
      target_left_in  = target_left_ff;
      target_right_in = target_right_ff;
      ramp_cap_in     = ramp_cap_ff;
      prev_error_in   = prev_error_ff;
      unchanged_in    = unchanged_ff;
      active_in       = active_ff;
      result          = '0;

      if (item.command == dspd_pkg::CMD_START) begin
         target_left_in  = dspd_pkg::TGT_W'(item.left_distance) +
                           dspd_pkg::TGT_W'(item.left_position);
         target_right_in = dspd_pkg::TGT_W'(item.right_distance) +
                           dspd_pkg::TGT_W'(item.right_position);
         ramp_cap_in     = '0;
         prev_error_in   = '0;
         unchanged_in    = '0;
         active_in       = 1'b1;
         result.running  = 1'b1;
      end else if (active_ff) begin
         ramp_cap_in  = cap;
         unchanged_in = count_next;
         if (settle) begin
            // The finishing tick gives zero drive and keeps the last mean error.
            active_in       = 1'b0;
            result.finished = 1'b1;
         end else begin
            prev_error_in      = mean_err[dspd_pkg::PREV_W-1:0];
            result.left_drive  = left_side.drive;
            result.right_drive = right_side.drive;
            result.running     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_left_ff  <= '0;
         target_right_ff <= '0;
         ramp_cap_ff     <= '0;
         prev_error_ff   <= '0;
         unchanged_ff    <= '0;
         active_ff       <= 1'b0;
      end else if (fire) begin
         target_left_ff  <= target_left_in;
         target_right_ff <= target_right_in;
         ramp_cap_ff     <= ramp_cap_in;
         prev_error_ff   <= prev_error_in;
         unchanged_ff    <= unchanged_in;
         active_ff       <= active_in;
      end
   end

endmodule

// ===== rtl/dual_side_p_drive_with_slew_and_settle_core.sv =====
// ----------------------------------------------------------------------------
// dual_side_p_drive_with_slew_and_settle_core
// Two-sided proportional position controller with slew-rate limited drive.
//
//   Channel  Direction  Handshake          Payload
//   req      in         req_valid/stall    command, positions, distances
//   rsp      out        rsp_valid/stall    drives, finished, running
//   csr      in/out     APB psel/penable   paddr, pwdata, prdata
//
// One transfer is accepted per cycle while req_stall is low; its result passes
// the input register, then the result register, before it is offered on rsp,
// with one 23x12 multiply and clamp path per side between the two registers.
// Reset is synchronous and returns the move state to idle and the
// configuration registers to their defaults.
// A stall on the result side holds the result register, and the input
// register then holds too, so req_stall rises only when both are full.
// ----------------------------------------------------------------------------
module dual_side_p_drive_with_slew_and_settle_core (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_command,
   input  logic signed [dspd_pkg::POS_W-1:0]   req_left_position,
   input  logic signed [dspd_pkg::POS_W-1:0]   req_right_position,
   input  logic signed [dspd_pkg::POS_W-1:0]   req_left_distance,
   input  logic signed [dspd_pkg::POS_W-1:0]   req_right_distance,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [dspd_pkg::DRV_W-1:0]   rsp_left_drive,
   output logic signed [dspd_pkg::DRV_W-1:0]   rsp_right_drive,
   output logic                                rsp_finished,
   output logic                                rsp_running,

   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [dspd_pkg::CSR_AW-1:0]         paddr,
   input  logic [dspd_pkg::CSR_DW-1:0]         pwdata,
   output logic [dspd_pkg::CSR_DW-1:0]         prdata,
   output logic                                pready
);

   dspd_pkg::cfg_type    cfg;
   dspd_pkg::item_type   item_ff;
   logic                 item_valid_ff;
   dspd_pkg::result_type result;
   dspd_pkg::result_type result_ff;
   logic                 result_valid_ff;
   logic                 out_free;
   logic                 fire;
   logic                 req_take;

   dspd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dspd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign out_free  = !result_valid_ff || !rsp_stall;
   assign fire      = item_valid_ff && out_free;
   assign req_stall = item_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff   <= 1'b0;
         result_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            item_valid_ff <= 1'b1;
         end else if (fire) begin
            item_valid_ff <= 1'b0;
         end
         if (fire) begin
            result_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            result_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.command        <= req_command;
         item_ff.left_position  <= req_left_position;
         item_ff.right_position <= req_right_position;
         item_ff.left_distance  <= req_left_distance;
         item_ff.right_distance <= req_right_distance;
      end
      if (fire) begin
         result_ff <= result;
      end
   end

   assign rsp_valid       = result_valid_ff;
   assign rsp_left_drive  = result_ff.left_drive;
   assign rsp_right_drive = result_ff.right_drive;
   assign rsp_finished    = result_ff.finished;
   assign rsp_running     = result_ff.running;

   // A finishing result never reports a move still running.
   a_finish_not_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished |-> !rsp_running)
      else $error("finished and running both set");

   // Drive is only given while a move runs.
   a_idle_zero_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_running |-> (rsp_left_drive == '0) && (rsp_right_drive == '0))
      else $error("nonzero drive without a running move");

   // The slew cap keeps drive magnitudes within seven bits.
   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_left_drive != 8'sh80) && (rsp_right_drive != 8'sh80))
      else $error("drive out of range");

   // An accepted transfer is held in the input register on the next cycle.
   a_take_loads: assert property (@(posedge clock) disable iff (reset)
      req_take |=> item_valid_ff)
      else $error("accepted transfer lost");

endmodule

// ===== tb/p_drive_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p_drive_checker
// Watches the request, result and register ports of the two-sided drive
// controller. It keeps its own copy of the move state and the register
// values, works out the expected result of every accepted request and
// compares it field by field with the result transfers in order.
// ----------------------------------------------------------------------------
module p_drive_checker
   import dspd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic                      req_command,
   input  logic signed [POS_W-1:0]   req_left_position,
   input  logic signed [POS_W-1:0]   req_right_position,
   input  logic signed [POS_W-1:0]   req_left_distance,
   input  logic signed [POS_W-1:0]   req_right_distance,

   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic signed [DRV_W-1:0]   rsp_left_drive,
   input  logic signed [DRV_W-1:0]   rsp_right_drive,
   input  logic                      rsp_finished,
   input  logic                      rsp_running,

   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_AW-1:0]         paddr,
   input  logic [CSR_DW-1:0]         pwdata,
   input  logic                      pready,

   output int                        mismatches,
   output int                        outstanding,
   output int                        transfers_checked,
   output int                        moves_ended
);

   cfg_type                  ctl;
   logic signed [TGT_W-1:0]  aim_left;
   logic signed [TGT_W-1:0]  aim_right;
   logic [CAP_W-1:0]         slew_cap;
   logic [PREV_W-1:0]        last_mean;
   logic [CNT_W-1:0]         still_ticks;
   logic                     move_live;
   result_type               expected_drives[$];

   function automatic int sign3(longint v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
   endfunction

   // Magnitude times Q4.8 gain, truncated, held to the slew cap, sign restored.
   function automatic logic [DRV_W-1:0] limited_drive(longint err, longint gain, longint cap);
      longint           m;
      logic [DRV_W-1:0] d;
      m = (((err < 0) ? -err : err) * gain) >> GAIN_FRAC;
      if (m > cap)
         m = cap;
      d = m[DRV_W-1:0];
      return (err < 0) ? -d : d;
   endfunction

   function automatic result_type advance_controller(item_type it);
      result_type r;
      longint     err_l;
      longint     err_r;
      longint     mean;
      longint     gain;
      longint     ramp;
      longint     cap;
      r = '0;
      if (it.command == CMD_START) begin
         aim_left    = $signed(it.left_distance) + $signed(it.left_position);
         aim_right   = $signed(it.right_distance) + $signed(it.right_position);
         slew_cap    = '0;
         last_mean   = '0;
         still_ticks = '0;
         move_live   = 1'b1;
         r.running   = 1'b1;
         return r;
      end
      if (!move_live)
         return r;

      err_l = longint'(aim_left) - longint'($signed(it.left_position));
      err_r = longint'(aim_right) - longint'($signed(it.right_position));
      mean  = (((err_l < 0) ? -err_l : err_l) + ((err_r < 0) ? -err_r : err_r)) >> 1;

      // A zero error has its own sign, so two zero errors count as straight.
      if (sign3(err_l) == sign3(err_r)) begin
         gain = ctl.gain_straight;
         ramp = ctl.ramp_straight;
      end else begin
         gain = ctl.gain_turn;
         ramp = ctl.ramp_turn;
      end
      cap = longint'(slew_cap) + ramp;
      if (cap > longint'(ctl.drive_limit))
         cap = ctl.drive_limit;
      slew_cap = cap[CAP_W-1:0];

      if (longint'(last_mean) == mean) begin
         if (still_ticks != '1)
            still_ticks++;
      end else begin
         still_ticks = '0;
      end

      if ((longint'(last_mean) < CLOSE_ERROR && mean < CLOSE_ERROR) ||
          still_ticks >= SETTLE_TICKS) begin
         move_live  = 1'b0;
         r.finished = 1'b1;
         return r;
      end

      last_mean     = mean[PREV_W-1:0];
      r.left_drive  = limited_drive(err_l, gain, cap);
      r.right_drive = limited_drive(err_r, gain, cap);
      r.running     = 1'b1;
      return r;
   endfunction

   function automatic void check_field(string name, logic signed [DRV_W-1:0] want_v,
                                       logic signed [DRV_W-1:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0d, actual %0d", name, want_v, got_v);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      item_type   it;
      result_type want;
      if (reset) begin
         ctl = {GAIN_STRAIGHT_RST, GAIN_TURN_RST, RAMP_STRAIGHT_RST, RAMP_TURN_RST,
                DRIVE_LIMIT_RST};
         aim_left          = '0;
         aim_right         = '0;
         slew_cap          = '0;
         last_mean         = '0;
         still_ticks       = '0;
         move_live         = 1'b0;
         expected_drives.delete();
         mismatches        = 0;
         outstanding       = 0;
         transfers_checked = 0;
         moves_ended       = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_IW+1:2])
               REG_GAIN_STRAIGHT: ctl.gain_straight = pwdata[GAIN_W-1:0];
               REG_GAIN_TURN:     ctl.gain_turn     = pwdata[GAIN_W-1:0];
               REG_RAMP_STRAIGHT: ctl.ramp_straight = pwdata[CAP_W-1:0];
               REG_RAMP_TURN:     ctl.ramp_turn     = pwdata[CAP_W-1:0];
               REG_DRIVE_LIMIT:   ctl.drive_limit   = pwdata[CAP_W-1:0];
               default: ;
            endcase
         end

         // Results are taken before new requests so that a transfer can never
         // be matched against an expectation pushed at the same edge.
         if (rsp_valid && !rsp_stall) begin
            if (expected_drives.size() == 0) begin
               $error("result transfer with no request waiting for it");
               mismatches++;
            end else begin
               want = expected_drives.pop_front();
               transfers_checked++;
               if (want.finished)
                  moves_ended++;
               check_field("left_drive", want.left_drive, rsp_left_drive);
               check_field("right_drive", want.right_drive, rsp_right_drive);
               check_field("finished", want.finished, rsp_finished);
               check_field("running", want.running, rsp_running);
            end
         end

         if (req_valid && !req_stall) begin
            it.command        = req_command;
            it.left_position  = req_left_position;
            it.right_position = req_right_position;
            it.left_distance  = req_left_distance;
            it.right_distance = req_right_distance;
            expected_drives.push_back(advance_controller(it));
         end
         outstanding = expected_drives.size();
      end
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the two-sided drive controller. Simulated moves
// (start, then encoder samples that close in, hold still, overshoot or jump)
// run under several register setups, mixed with random noise requests,
// random gaps on both sides and one long result-side hold-off.
// ----------------------------------------------------------------------------
module tb_top;
   import dspd_pkg::*;

   localparam int POS_MAX = 2 ** (POS_W - 1) - 1;
   localparam int POS_MIN = -(2 ** (POS_W - 1));

   typedef enum int {MOVE_CONVERGE, MOVE_TURN, MOVE_STUCK, MOVE_CLOSE} move_kind_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic                     req_command;
   logic signed [POS_W-1:0]  req_left_position;
   logic signed [POS_W-1:0]  req_right_position;
   logic signed [POS_W-1:0]  req_left_distance;
   logic signed [POS_W-1:0]  req_right_distance;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic signed [DRV_W-1:0]  rsp_left_drive;
   logic signed [DRV_W-1:0]  rsp_right_drive;
   logic                     rsp_finished;
   logic                     rsp_running;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_AW-1:0]        paddr;
   logic [CSR_DW-1:0]        pwdata;
   logic [CSR_DW-1:0]        prdata;
   logic                     pready;

   int                       mismatches;
   int                       outstanding;
   int                       transfers_checked;
   int                       moves_ended;

   int                       sent_items = 0;
   move_kind_type            kind = MOVE_CONVERGE;
   int                       aim_l = 0;
   int                       aim_r = 0;
   int                       err_l = 0;
   int                       err_r = 0;
   int                       ticks_left = 0;

   dual_side_p_drive_with_slew_and_settle_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_left_position  (req_left_position),
      .req_right_position (req_right_position),
      .req_left_distance  (req_left_distance),
      .req_right_distance (req_right_distance),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_left_drive     (rsp_left_drive),
      .rsp_right_drive    (rsp_right_drive),
      .rsp_finished       (rsp_finished),
      .rsp_running        (rsp_running),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   p_drive_checker drive_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_left_position  (req_left_position),
      .req_right_position (req_right_position),
      .req_left_distance  (req_left_distance),
      .req_right_distance (req_right_distance),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_left_drive     (rsp_left_drive),
      .rsp_right_drive    (rsp_right_drive),
      .rsp_finished       (rsp_finished),
      .rsp_running        (rsp_running),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .pready             (pready),
      .mismatches         (mismatches),
      .outstanding        (outstanding),
      .transfers_checked  (transfers_checked),
      .moves_ended        (moves_ended)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Neither side draws random gaps or stalls during this window.
   function automatic bit quiet_stretch();
      return sent_items >= 400 && sent_items < 560;
   endfunction

   function automatic int rand_full();
      return int'($urandom_range(0, 2 ** POS_W - 1)) + POS_MIN;
   endfunction

   function automatic int fit_pos(int v);
      if (v > POS_MAX)
         return POS_MAX;
      if (v < POS_MIN)
         return POS_MIN;
      return v;
   endfunction

   task automatic offer(input logic cmd, input int lp, input int rp, input int ld,
                        input int rd);
      int gap;
      gap = 0;
      if (!quiet_stretch())
         while ($urandom_range(0, 99) < 6)
            gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_command        <= cmd;
      req_left_position  <= lp[POS_W-1:0];
      req_right_position <= rp[POS_W-1:0];
      req_left_distance  <= ld[POS_W-1:0];
      req_right_distance <= rd[POS_W-1:0];
      do @(posedge clock); while (req_stall);
      sent_items++;
   endtask

   task automatic begin_move(input move_kind_type k, input bit wide);
      int pl;
      int pr;
      int dl;
      int dr;
      kind = k;
      if (wide) begin
         pl = rand_full();
         pr = rand_full();
         dl = rand_full();
         dr = rand_full();
      end else begin
         pl = int'($urandom_range(0, 100000)) - 50000;
         pr = int'($urandom_range(0, 100000)) - 50000;
         dl = $urandom_range(5, 3000);
         dr = $urandom_range(5, 3000);
         if ($urandom_range(0, 1)) begin
            dl = -dl;
            dr = -dr;
         end
         if (k == MOVE_TURN)
            dr = -dr;
      end
      if (k == MOVE_CLOSE) begin
         dl = int'($urandom_range(0, 12)) - 6;
         dr = int'($urandom_range(0, 12)) - 6;
      end
      aim_l      = pl + dl;
      aim_r      = pr + dr;
      err_l      = dl;
      err_r      = dr;
      // A stuck move needs twenty unchanged ticks after its first sample.
      ticks_left = (k == MOVE_STUCK) ? $urandom_range(21, 26) : $urandom_range(3, 40);
      offer(CMD_START, pl, pr, dl, dr);
   endtask

   task automatic offer_sample();
      int r;
      int k;
      int pl;
      int pr;
      r = $urandom_range(0, 99);
      k = $urandom_range(1, 4);
      if (kind != MOVE_STUCK) begin
         if (r < 70) begin
            err_l = (err_l > -8 && err_l < 8) ? err_l / 2 : err_l - err_l * k / 8;
            err_r = (err_r > -8 && err_r < 8) ? err_r / 2 : err_r - err_r * k / 8;
         end else if (r >= 80 && r < 88) begin
            err_r = -err_r;
         end else if (r >= 88) begin
            err_l += int'($urandom_range(0, 20)) - 10;
            err_r += int'($urandom_range(0, 20)) - 10;
         end
      end
      pl    = fit_pos(aim_l - err_l);
      pr    = fit_pos(aim_r - err_r);
      err_l = aim_l - pl;
      err_r = aim_r - pr;
      ticks_left--;
      offer(CMD_SAMPLE, pl, pr, rand_full(), rand_full());
   endtask

   task automatic next_move_item();
      int   pick;
      logic cmd;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         cmd = 1'($urandom_range(0, 1));
         offer(cmd, rand_full(), rand_full(), rand_full(), rand_full());
      end else if (ticks_left <= 0) begin
         begin_move(move_kind_type'($urandom_range(0, 3)), pick < 20);
      end else begin
         offer_sample();
      end
   endtask

   // Leaves a move running with a large error so that it carries across the
   // next register update.
   task automatic carry_move();
      begin_move(MOVE_CONVERGE, 1'b1);
      ticks_left = 30;
      offer_sample();
      offer_sample();
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IW-1:0] index, input logic [CSR_DW-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
   endtask

   task automatic program_phase(input int phase);
      logic [CSR_DW-1:0] gs;
      logic [CSR_DW-1:0] gt;
      logic [CSR_DW-1:0] rs;
      logic [CSR_DW-1:0] rt;
      logic [CSR_DW-1:0] lim;
      gs  = $urandom_range(0, 4095);
      gt  = $urandom_range(0, 4095);
      rs  = $urandom_range(1, 127);
      rt  = $urandom_range(1, 127);
      lim = $urandom_range(0, 127);
      case (phase)
         1: begin
            gs  = 4095;
            gt  = 4095;
            rs  = 127;
            rt  = 127;
            lim = 127;
         end
         2: begin
            // The move carried over sits at a cap of 127, well above this limit.
            rs  = $urandom_range(1, 10);
            rt  = $urandom_range(1, 10);
            lim = 20;
         end
         3: begin
            gs  = 0;
            gt  = 0;
            rs  = 0;
            rt  = 0;
            lim = 0;
         end
         default: ;
      endcase
      write_reg(REG_GAIN_STRAIGHT, gs);
      write_reg(REG_GAIN_TURN, gt);
      write_reg(REG_RAMP_STRAIGHT, rs);
      write_reg(REG_RAMP_TURN, rt);
      write_reg(REG_DRIVE_LIMIT, lim);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Result side: random stalls, plus one long hold-off so the block fills up.
   initial begin
      int  held;
      bit  hold_done;
      hold_done = 1'b0;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if (!hold_done && sent_items >= 250) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            for (held = 0; held < 60; held++)
               @(posedge clock);
         end
         rsp_stall <= !quiet_stretch() && ($urandom_range(0, 99) < 6);
         @(posedge clock);
      end
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      int phase;
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_command        <= CMD_SAMPLE;
      req_left_position  <= '0;
      req_right_position <= '0;
      req_left_distance  <= '0;
      req_right_distance <= '0;
      psel               <= 1'b0;
      penable            <= 1'b0;
      pwrite             <= 1'b0;
      paddr              <= '0;
      pwdata             <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset register values.
      offer(CMD_SAMPLE, POS_MAX, POS_MIN, POS_MAX, POS_MIN);  // no move yet
      offer(CMD_START, POS_MIN, POS_MAX, POS_MIN, POS_MAX);   // targets at both ends
      offer(CMD_SAMPLE, POS_MAX, POS_MIN, 0, 0);              // largest opposite errors
      offer(CMD_SAMPLE, POS_MAX, POS_MIN, POS_MIN, POS_MAX);  // mean error unchanged
      offer(CMD_START, 0, 0, 0, 0);                           // restart while running
      offer(CMD_SAMPLE, 0, 0, POS_MAX, POS_MAX);              // both errors zero
      offer(CMD_SAMPLE, -1, -1, -1, -1);                      // ignored after the end
      offer(CMD_START, -1, 1, 3, -4);
      offer(CMD_SAMPLE, -1, 1, 0, 0);                         // close on the first tick
      offer(CMD_START, 100, -100, 1000, 1000);
      offer(CMD_SAMPLE, 100, -100, 0, 0);
      offer(CMD_SAMPLE, 1100, -100, 0, 0);                    // one side exactly on target
      offer(CMD_SAMPLE, 1103, 897, 0, 0);
      offer(CMD_SAMPLE, 1102, 898, 0, 0);                     // close on two ticks

      for (phase = 0; phase < 6; phase++) begin
         if (phase > 0) begin
            drain();
            program_phase(phase);
         end
         repeat (150) next_move_item();
         carry_move();
      end
      drain();
      repeat (8) @(posedge clock);

      $display("Checked %0d result transfers; %0d moves reached their end.",
               transfers_checked, moves_ended);
      $display("Moves ran under six register setups, among them all-maximum and all-zero.");
      if (mismatches == 0 && outstanding == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/dspd_pkg.sv
rtl/dspd_csr.sv
rtl/dspd_side.sv
rtl/dspd_ctrl.sv
rtl/dual_side_p_drive_with_slew_and_settle_core.sv
tb/p_drive_checker.sv
tb/tb_top.sv
